### design/rgb_pkg.sv
// shared types, widths and register codes of the rectangle grid binner
// used by rgb_quot, rect_grid_binner and rgb_checker; no dependencies
package rgb_pkg;

  localparam int DATA_W    = 32;
  localparam int PITCH_W   = 30;
  localparam int CNT_W     = 4;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 3;
  // bin edges reach at most origin + 8 pitches + margin, so 36 signed bits never wrap
  localparam int EW        = 36;

  localparam int S_TDATA_W = 4 * DATA_W;
  localparam int PIECE_W   = 2 * IDX_W + 4 * DATA_W;
  localparam int M_TDATA_W = ((PIECE_W + 7) / 8) * 8;

  localparam int MAX_COLUMNS_DEF = 8;
  localparam int MAX_ROWS_DEF    = 8;

  // quotient saturates here; no grid is larger
  localparam logic [CNT_W-1:0] QUOT_SAT = CNT_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_Y   = 3'd7;

  typedef logic signed [EW-1:0] edge_t;

  typedef struct packed {
    logic              start;
    logic [EW-1:0]     dividend;
    logic [PITCH_W-1:0] divisor;
  } quot_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quot;
  } quot_rsp_t;

  // lowest field last, so col lands in the low bits of tdata
  typedef struct packed {
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] right;
    logic [DATA_W-1:0] bottom;
    logic [DATA_W-1:0] left;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } piece_t;

  function automatic edge_t sext32(input logic [DATA_W-1:0] v);
    return edge_t'({{(EW-DATA_W){v[DATA_W-1]}}, v});
  endfunction

endpackage

### design/rgb_quot.sv
// shared quotient unit: min(floor(dividend / divisor), 8) for a nonnegative dividend
// restoring compare-subtract, one step per cycle; uses rgb_pkg
module rgb_quot (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rgb_pkg::quot_req_t req_i,
  output rgb_pkg::quot_rsp_t rsp_o
);

  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [1:0]                  step_q, step_d;
  logic [rgb_pkg::EW-1:0]      rem_q, rem_d;
  logic [rgb_pkg::CNT_W-1:0]   quot_q, quot_d;
  logic [rgb_pkg::PITCH_W-1:0] div_q, div_d;
  logic [rgb_pkg::EW-1:0]      shifted;
  logic                        ge;

  assign shifted = rgb_pkg::EW'(div_q) << step_q;
  assign ge      = rem_q >= shifted;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    div_d  = div_q;
    if (req_i.start) begin
      run_d  = 1'b1;
      step_d = 2'd3;
      rem_d  = req_i.dividend;
      quot_d = '0;
      div_d  = req_i.divisor;
    end else if (run_q) begin
      if (step_q == 2'd3) begin
        // first step only checks for saturation at eight pitches
        if (ge) begin
          quot_d = rgb_pkg::QUOT_SAT;
          run_d  = 1'b0;
          done_d = 1'b1;
        end else begin
          step_d = 2'd2;
        end
      end else begin
        if (ge) begin
          rem_d          = rem_q - shifted;
          quot_d[step_q] = 1'b1;
        end
        if (step_q == 2'd0) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end else begin
          step_d = step_q - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### design/rect_grid_binner.sv
// top level of the rectangle grid binner: config registers, sequencer, bin walk
// depends on rgb_pkg and rgb_quot
//
// Usage: write the grid registers on the cfg port while idle, then send one
// rectangle per word on s_axis (left, bottom, right, top). For each bin the
// rectangle overlaps, rows outer and columns inner, one word leaves on m_axis
// with the bin coordinates and the rectangle clipped to the bloated bin;
// tlast marks the final word of the rectangle. Empty clips, degenerate and
// rejected rectangles give no word.
// Timing: the block takes one rectangle at a time (s_axis_tready is high only
// while idle). The x and y edge quotients run in turn through the shared rgb_quot
// unit; an edge that lies before the grid needs no quotient, and a quotient
// that saturates ends early. The walk then handles one visited row or one
// visited bin per cycle while the receiver keeps up, and a flush state
// releases the held-back final word. A dropped rectangle returns the block
// to idle without a walk.
// One word is held back until the next is known, so tlast is exact; a second
// register drives m_axis. If the receiver stalls, the walk pauses; the last
// word may still wait on m_axis while the next rectangle is taken.
// Reset clears the control state and loads the register reset values
// (origins 0, one column and row, pitch 1, margins 0).
module rect_grid_binner #(
  parameter int unsigned MAX_COLUMNS = rgb_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = rgb_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rgb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rgb_pkg::DATA_W-1:0]      cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // rect_left, rect_bottom, rect_right, rect_top
  input  logic [rgb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // bin_column, bin_row, clip_left, clip_bottom, clip_right, clip_top, zero pad
  output logic [rgb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // last_piece
  output logic                            m_axis_tlast
);

  localparam int DW = rgb_pkg::DATA_W;
  localparam int EW = rgb_pkg::EW;
  localparam int PW = rgb_pkg::PITCH_W;
  localparam int CW = rgb_pkg::CNT_W;
  localparam int IW = rgb_pkg::IDX_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_SETUP = 3'd4;
  localparam logic [2:0] ST_ROW   = 3'd5;
  localparam logic [2:0] ST_COL   = 3'd6;
  localparam logic [2:0] ST_FLUSH = 3'd7;

  // configuration registers
  logic [DW-1:0] origin_x_q, origin_y_q;
  logic [CW-1:0] columns_q, rows_q;
  logic [PW-1:0] bin_width_q, bin_height_q, margin_x_q, margin_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      columns_q    <= CW'(1);
      rows_q       <= CW'(1);
      bin_width_q  <= PW'(1);
      bin_height_q <= PW'(1);
      margin_x_q   <= '0;
      margin_y_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgb_pkg::REG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        rgb_pkg::REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        rgb_pkg::REG_COLUMNS:    columns_q    <= cfg_data_i[CW-1:0];
        rgb_pkg::REG_ROWS:       rows_q       <= cfg_data_i[CW-1:0];
        rgb_pkg::REG_BIN_WIDTH:  bin_width_q  <= cfg_data_i[PW-1:0];
        rgb_pkg::REG_BIN_HEIGHT: bin_height_q <= cfg_data_i[PW-1:0];
        rgb_pkg::REG_MARGIN_X:   margin_x_q   <= cfg_data_i[PW-1:0];
        rgb_pkg::REG_MARGIN_Y:   margin_y_q   <= cfg_data_i[PW-1:0];
      endcase
    end
  end

  // effective grid values
  logic [CW-1:0] ncol, nrow;
  logic [PW-1:0] dx, dy;

  always_comb begin
    if (columns_q == '0)                   ncol = CW'(1);
    else if (columns_q > CW'(MAX_COLUMNS)) ncol = CW'(MAX_COLUMNS);
    else                                   ncol = columns_q;
    if (rows_q == '0)                      nrow = CW'(1);
    else if (rows_q > CW'(MAX_ROWS))       nrow = CW'(MAX_ROWS);
    else                                   nrow = rows_q;
    dx = (bin_width_q == '0)  ? PW'(1) : bin_width_q;
    dy = (bin_height_q == '0) ? PW'(1) : bin_height_q;
  end

  // sequencer and walk state
  logic [2:0]          state_q, state_d;
  logic [1:0]          job_q, job_d;
  logic [DW-1:0]       left_q, left_d, bottom_q, bottom_d;
  logic [DW-1:0]       right_q, right_d, top_q, top_d;
  logic [IW-1:0]       c0_q, c0_d, c1_q, c1_d, r0_q, r0_d, r1_q, r1_d;
  logic [IW-1:0]       col_q, col_d, row_q, row_d;
  rgb_pkg::edge_t      xs_lo_q, xs_lo_d, xs_hi_q, xs_hi_d;
  rgb_pkg::edge_t      x_lo_q, x_lo_d, x_hi_q, x_hi_d;
  rgb_pkg::edge_t      y_lo_q, y_lo_d, y_hi_q, y_hi_d;
  rgb_pkg::edge_t      yb_q, yb_d, yt_q, yt_d;
  logic                pend_v_q, pend_v_d;
  rgb_pkg::piece_t     pend_q, pend_d;
  logic                out_v_q, out_v_d, out_last_q, out_last_d;
  rgb_pkg::piece_t     out_q, out_d;

  rgb_pkg::quot_req_t  quot_req;
  rgb_pkg::quot_rsp_t  quot_rsp;

  rgb_quot u_quot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (quot_req),
    .rsp_o  (quot_rsp)
  );

  // per-job operand selection: jobs are first x, last x, first y, last y
  logic           axis_y, is_last;
  logic [DW-1:0]  sel_lo, sel_hi, sel_org;
  logic [PW-1:0]  sel_m, sel_p;
  logic [CW-1:0]  sel_cnt, cnt_m1;
  rgb_pkg::edge_t op_first, op_last, op;

  assign axis_y  = job_q[1];
  assign is_last = job_q[0];
  assign sel_lo  = axis_y ? bottom_q   : left_q;
  assign sel_hi  = axis_y ? top_q      : right_q;
  assign sel_org = axis_y ? origin_y_q : origin_x_q;
  assign sel_m   = axis_y ? margin_y_q : margin_x_q;
  assign sel_p   = axis_y ? dy         : dx;
  assign sel_cnt = axis_y ? nrow       : ncol;
  assign cnt_m1  = sel_cnt - CW'(1);

  assign op_first = rgb_pkg::sext32(sel_lo) - rgb_pkg::sext32(sel_org)
                    - $signed(EW'(sel_m));
  assign op_last  = rgb_pkg::sext32(sel_hi) - rgb_pkg::sext32(sel_org)
                    + $signed(EW'(sel_m)) - $signed(EW'(1));
  assign op       = is_last ? op_last : op_first;

  assign quot_req.start    = (state_q == ST_LOAD) && !op[EW-1];
  assign quot_req.dividend = op;
  assign quot_req.divisor  = sel_p;

  // low and high edges of the first column and row
  logic [CW-1:0]     c0_next, r0_next;
  logic [IW+PW-1:0]  cx_lo, ry_lo;
  logic [CW+PW-1:0]  cx_hi, ry_hi;

  assign c0_next = {1'b0, c0_q} + CW'(1);
  assign r0_next = {1'b0, r0_q} + CW'(1);
  assign cx_lo   = c0_q * dx;
  assign ry_lo   = r0_q * dy;
  assign cx_hi   = c0_next * dx;
  assign ry_hi   = r0_next * dy;

  // clip against the current bloated bin
  rgb_pkg::edge_t rl, rr, rb, rt, xl, xr, ybc, ytc;
  logic           found, out_free, adv;

  assign rl  = rgb_pkg::sext32(left_q);
  assign rr  = rgb_pkg::sext32(right_q);
  assign rb  = rgb_pkg::sext32(bottom_q);
  assign rt  = rgb_pkg::sext32(top_q);
  assign xl  = (rl > x_lo_q) ? rl : x_lo_q;
  assign xr  = (rr < x_hi_q) ? rr : x_hi_q;
  assign ybc = (rb > y_lo_q) ? rb : y_lo_q;
  assign ytc = (rt < y_hi_q) ? rt : y_hi_q;
  assign found    = xr > xl;
  assign out_free = !out_v_q || m_axis_tready;
  // a found word needs room only if one is already held back
  assign adv      = !found || !pend_v_q || out_free;

  rgb_pkg::piece_t new_piece;

  always_comb begin
    new_piece.col    = col_q;
    new_piece.row    = row_q;
    new_piece.left   = xl[DW-1:0];
    new_piece.bottom = yb_q[DW-1:0];
    new_piece.right  = xr[DW-1:0];
    new_piece.top    = yt_q[DW-1:0];
  end

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    left_d     = left_q;
    bottom_d   = bottom_q;
    right_d    = right_q;
    top_d      = top_q;
    c0_d       = c0_q;
    c1_d       = c1_q;
    r0_d       = r0_q;
    r1_d       = r1_q;
    col_d      = col_q;
    row_d      = row_q;
    xs_lo_d    = xs_lo_q;
    xs_hi_d    = xs_hi_q;
    x_lo_d     = x_lo_q;
    x_hi_d     = x_hi_q;
    y_lo_d     = y_lo_q;
    y_hi_d     = y_hi_q;
    yb_d       = yb_q;
    yt_d       = yt_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;

    if (out_v_q && m_axis_tready) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          left_d   = s_axis_tdata[DW-1:0];
          bottom_d = s_axis_tdata[2*DW-1:DW];
          right_d  = s_axis_tdata[3*DW-1:2*DW];
          top_d    = s_axis_tdata[4*DW-1:3*DW];
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ($signed(right_q) <= $signed(left_q) || $signed(top_q) <= $signed(bottom_q)) begin
          state_d = ST_IDLE;
        end else begin
          job_d   = 2'd0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (op[EW-1]) begin
          // before the grid: a first edge gives index zero, a last edge drops the rectangle
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            if (axis_y) r0_d = '0;
            else        c0_d = '0;
            job_d = job_q + 2'd1;
          end
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (quot_rsp.done) begin
          if (!is_last && quot_rsp.quot >= sel_cnt) begin
            state_d = ST_IDLE;
          end else begin
            if (!is_last) begin
              if (axis_y) r0_d = quot_rsp.quot[IW-1:0];
              else        c0_d = quot_rsp.quot[IW-1:0];
            end else begin
              if (axis_y) r1_d = (quot_rsp.quot > cnt_m1) ? cnt_m1[IW-1:0]
                                                         : quot_rsp.quot[IW-1:0];
              else        c1_d = (quot_rsp.quot > cnt_m1) ? cnt_m1[IW-1:0]
                                                         : quot_rsp.quot[IW-1:0];
            end
            if (job_q == 2'd3) begin
              state_d = ST_SETUP;
            end else begin
              job_d   = job_q + 2'd1;
              state_d = ST_LOAD;
            end
          end
        end
      end
      ST_SETUP: begin
        xs_lo_d = rgb_pkg::sext32(origin_x_q) + $signed(EW'(cx_lo))
                  - $signed(EW'(margin_x_q));
        xs_hi_d = rgb_pkg::sext32(origin_x_q) + $signed(EW'(cx_hi))
                  + $signed(EW'(margin_x_q));
        y_lo_d  = rgb_pkg::sext32(origin_y_q) + $signed(EW'(ry_lo))
                  - $signed(EW'(margin_y_q));
        y_hi_d  = rgb_pkg::sext32(origin_y_q) + $signed(EW'(ry_hi))
                  + $signed(EW'(margin_y_q));
        row_d   = r0_q;
        state_d = ST_ROW;
      end
      ST_ROW: begin
        yb_d = ybc;
        yt_d = ytc;
        if (ytc > ybc) begin
          col_d   = c0_q;
          x_lo_d  = xs_lo_q;
          x_hi_d  = xs_hi_q;
          state_d = ST_COL;
        end else if (row_q == r1_q) begin
          state_d = ST_FLUSH;
        end else begin
          row_d  = row_q + IW'(1);
          y_lo_d = y_lo_q + $signed(EW'(dy));
          y_hi_d = y_hi_q + $signed(EW'(dy));
        end
      end
      ST_COL: begin
        if (adv) begin
          if (found) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_d      = pend_q;
              out_last_d = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = new_piece;
          end
          if (col_q == c1_q) begin
            if (row_q == r1_q) begin
              state_d = ST_FLUSH;
            end else begin
              row_d   = row_q + IW'(1);
              y_lo_d  = y_lo_q + $signed(EW'(dy));
              y_hi_d  = y_hi_q + $signed(EW'(dy));
              state_d = ST_ROW;
            end
          end else begin
            col_d  = col_q + IW'(1);
            x_lo_d = x_lo_q + $signed(EW'(dx));
            x_hi_d = x_hi_q + $signed(EW'(dx));
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = pend_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      job_q    <= 2'd0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      job_q    <= job_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q     <= left_d;
    bottom_q   <= bottom_d;
    right_q    <= right_d;
    top_q      <= top_d;
    c0_q       <= c0_d;
    c1_q       <= c1_d;
    r0_q       <= r0_d;
    r1_q       <= r1_d;
    col_q      <= col_d;
    row_q      <= row_d;
    xs_lo_q    <= xs_lo_d;
    xs_hi_q    <= xs_hi_d;
    x_lo_q     <= x_lo_d;
    x_hi_q     <= x_hi_d;
    y_lo_q     <= y_lo_d;
    y_hi_q     <= y_hi_d;
    yb_q       <= yb_d;
    yt_q       <= yt_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = rgb_pkg::M_TDATA_W'(out_q);
  assign m_axis_tlast  = out_last_q;

endmodule

### design/rgb_checker.sv
// port-level checks for rect_grid_binner, attached by the bind below
// depends on rgb_pkg
module rgb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rgb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // and does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // one rectangle at a time: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // a new rectangle cannot produce a word in the very next cycle
  a_no_early_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("output word appeared right after input accept");

endmodule

bind rect_grid_binner rgb_checker u_rgb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/testbench.sv
// self-checking testbench for rect_grid_binner: directed table, then random grids and rectangles
// predicts every bin piece in-house and scores m_axis words against it; depends on rgb_pkg
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb_pkg::*;

  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam int MAX_PIECES = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [31:0] left;
    logic signed [31:0] bottom;
    logic signed [31:0] right;
    logic signed [31:0] top;
  } rect_t;

  typedef struct {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [31:0]      left;
    logic [31:0]      bottom;
    logic [31:0]      right;
    logic [31:0]      top;
    logic             last;
  } bin_word_t;

  typedef enum {STEP_CFG, STEP_PREDICT, STEP_DROP, STEP_SINGLE} step_kind_e;
  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          val;
    rect_t                rect;
    bin_word_t            want;
  } step_t;

  localparam rect_t NO_RECT = '{0, 0, 0, 0};
  localparam bin_word_t NO_WORD = '{0, 0, 0, 0, 0, 0, 0};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  rect_grid_binner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the grid registers
  longint        grid_org_x = 0;
  longint        grid_org_y = 0;
  logic [3:0]    grid_cols = 4'd1;
  logic [3:0]    grid_rows = 4'd1;
  logic [29:0]   pitch_x = 30'd1;
  logic [29:0]   pitch_y = 30'd1;
  logic [29:0]   bloat_x = '0;
  logic [29:0]   bloat_y = '0;

  bin_word_t     expected_bins[$];
  step_t         plan[$];
  idle_e         idle_mode = IDLE_NONE;
  bit            need_settle = 1'b0;
  bit            pressure_go = 1'b0;
  bit            pressure_done = 1'b0;
  int            stall_left = 0;
  int            fail_count = 0;
  int            rect_count = 0;
  int            piece_count = 0;
  int            grid_count = 0;

  function automatic longint clamp_count(input logic [3:0] n);
    if (n == 0) return 1;
    if (n > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return longint'(n);
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > longint'(S_MAX)) return S_MAX;
    if (v < longint'(S_MIN)) return S_MIN;
    return 32'(v);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_ORIGIN_X:   grid_org_x = longint'(signed'(val));
      REG_ORIGIN_Y:   grid_org_y = longint'(signed'(val));
      REG_COLUMNS:    grid_cols = val[3:0];
      REG_ROWS:       grid_rows = val[3:0];
      REG_BIN_WIDTH:  pitch_x = val[29:0];
      REG_BIN_HEIGHT: pitch_y = val[29:0];
      REG_MARGIN_X:   bloat_x = val[29:0];
      REG_MARGIN_Y:   bloat_y = val[29:0];
      default: ;
    endcase
  endfunction

  // first and last bin touched on one axis; 0 when the rectangle misses the grid
  function automatic bit axis_span(input longint lo, input longint hi, input longint org,
                                   input longint pitch, input longint bloat, input longint cnt,
                                   output longint first, output longint last);
    longint d, e;
    d = lo - (org + bloat);
    e = hi - (org - bloat) - 1;
    first = 0;
    last = 0;
    if (d >= 0) begin
      if (d >= cnt * pitch) return 0;
      first = d / pitch;
    end
    if (e < 0) return 0;
    last = e / pitch;
    if (last > cnt - 1) last = cnt - 1;
    return 1;
  endfunction

  function automatic void predict_bins(input rect_t r);
    longint l, b, rt, t, ncol, nrow, dx, dy, mx, my;
    longint c0, c1, r0, r1, yb, yt, xl, xr;
    bin_word_t w;
    bin_word_t found[$];
    l = r.left;
    b = r.bottom;
    rt = r.right;
    t = r.top;
    ncol = clamp_count(grid_cols);
    nrow = clamp_count(grid_rows);
    dx = (pitch_x == 0) ? 1 : longint'(pitch_x);
    dy = (pitch_y == 0) ? 1 : longint'(pitch_y);
    mx = longint'(bloat_x);
    my = longint'(bloat_y);
    if (rt <= l || t <= b) return;
    if (!axis_span(l, rt, grid_org_x, dx, mx, ncol, c0, c1)) return;
    if (!axis_span(b, t, grid_org_y, dy, my, nrow, r0, r1)) return;
    for (longint i = r0; i <= r1; i++) begin
      yb = grid_org_y + i * dy - my;
      yt = grid_org_y + (i + 1) * dy + my;
      if (b > yb) yb = b;
      if (t < yt) yt = t;
      if (yt <= yb) continue;
      for (longint j = c0; j <= c1; j++) begin
        xl = grid_org_x + j * dx - mx;
        xr = grid_org_x + (j + 1) * dx + mx;
        if (l > xl) xl = l;
        if (rt < xr) xr = rt;
        if (xr <= xl) continue;
        if (found.size() >= MAX_PIECES) break;
        w.col = 3'(j);
        w.row = 3'(i);
        w.left = 32'(xl);
        w.bottom = 32'(yb);
        w.right = 32'(xr);
        w.top = 32'(yt);
        w.last = 1'b0;
        found.push_back(w);
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[k]) expected_bins.push_back(found[k]);
  endfunction

  // a coordinate near a bin edge, a bloated edge or inside a bin; its bin edge lies one bin beyond the grid at most
  function automatic longint grid_point(input longint org, input longint pitch,
                                        input longint bloat, input longint cnt);
    longint k, p;
    k = longint'($urandom_range(0, int'(cnt) + 1)) - 1;
    p = org + k * pitch;
    case ($urandom_range(0, 4))
      0: ;
      1: p = p - bloat;
      2: p = p + bloat;
      3: p = p + longint'($urandom_range(0, 32'(pitch - 1)));
      default: p = p + longint'($urandom_range(0, 2)) - 1;
    endcase
    return p;
  endfunction

  function automatic rect_t random_rect();
    rect_t r;
    longint x0, x1, y0, y1, tmp, dx, dy;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.left = $urandom;
      r.bottom = $urandom;
      r.right = $urandom;
      r.top = $urandom;
      return r;
    end
    dx = (pitch_x == 0) ? 1 : longint'(pitch_x);
    dy = (pitch_y == 0) ? 1 : longint'(pitch_y);
    x0 = grid_point(grid_org_x, dx, longint'(bloat_x), clamp_count(grid_cols));
    x1 = grid_point(grid_org_x, dx, longint'(bloat_x), clamp_count(grid_cols));
    y0 = grid_point(grid_org_y, dy, longint'(bloat_y), clamp_count(grid_rows));
    y1 = grid_point(grid_org_y, dy, longint'(bloat_y), clamp_count(grid_rows));
    if (x1 < x0) begin tmp = x0; x0 = x1; x1 = tmp; end
    if (y1 < y0) begin tmp = y0; y0 = y1; y1 = tmp; end
    if (x1 == x0) x1++;
    if (y1 == y0) y1++;
    // broken rectangles: one axis flipped or flattened
    if (pick < 30) begin
      if ($urandom_range(0, 1)) begin
        tmp = x0; x0 = x1; x1 = ($urandom_range(0, 1)) ? tmp : x0;
      end else begin
        tmp = y0; y0 = y1; y1 = ($urandom_range(0, 1)) ? tmp : y0;
      end
    end
    r.left = sat32(x0);
    r.right = sat32(x1);
    r.bottom = sat32(y0);
    r.top = sat32(y1);
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic settle_stream();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    // a dropped rectangle may still be in the range search
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    if (need_settle) settle_stream();
    need_settle = 1'b0;
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic send_rect(input rect_t r);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 81 : (idle_mode == IDLE_BOTH) ? 6 : 0;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.top, r.right, r.bottom, r.left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    need_settle = 1'b1;
    rect_count++;
  endtask

  task automatic random_grid();
    logic [31:0] v;
    for (int k = 0; k < 8; k++) begin
      case (k)
        REG_ORIGIN_X, REG_ORIGIN_Y: begin
          case ($urandom_range(0, 3))
            0, 1: v = $urandom_range(0, 2000) - 1000;
            2: v = $urandom;
            default: v = $urandom_range(0, 1) ? S_MAX : S_MIN;
          endcase
        end
        REG_COLUMNS, REG_ROWS: v = $urandom;
        REG_BIN_WIDTH, REG_BIN_HEIGHT: begin
          case ($urandom_range(0, 3))
            0, 1: v = {2'($urandom), 30'($urandom_range(1, 20))};
            2: v = {2'($urandom), 30'($urandom_range(1, 1000))};
            default: v = $urandom;
          endcase
        end
        default: begin
          case ($urandom_range(0, 2))
            0: v = {2'($urandom), 30'd0};
            1: v = {2'($urandom), 30'($urandom_range(0, 12))};
            default: v = $urandom;
          endcase
        end
      endcase
      program_reg(CFG_IDX_W'(k), v);
    end
    grid_count++;
  endtask

  // receiver: random stalls by phase, plus one long hold to back the block up
  always @(negedge clk_i) begin
    if (pressure_go && !pressure_done) begin
      stall_left = 400;
      pressure_done = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECV: m_axis_tready <= ($urandom_range(0, 99) >= 81);
        IDLE_BOTH: m_axis_tready <= ($urandom_range(0, 99) >= 6);
        default:   m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin : score_words
    piece_t    got;
    bin_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = piece_t'(m_axis_tdata[PIECE_W-1:0]);
      piece_count++;
      if (expected_bins.size() == 0) begin
        $error("word with no pending piece: col %0d row %0d", got.col, got.row);
        fail_count++;
      end else begin
        want = expected_bins.pop_front();
        check_field("bin_column", want.col, got.col);
        check_field("bin_row", want.row, got.row);
        check_field("clip_left", want.left, got.left);
        check_field("clip_bottom", want.bottom, got.bottom);
        check_field("clip_right", want.right, got.right);
        check_field("clip_top", want.top, got.top);
        check_field("last_piece", want.last, m_axis_tlast);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    step_t s;
    rect_t r;

    // reset grid: one bin of pitch 1 at the origin
    plan.push_back(step_t'{STEP_SINGLE, REG_ORIGIN_X, 0, '{0, 0, 1, 1}, '{0, 0, 0, 0, 1, 1, 1}});
    plan.push_back(step_t'{STEP_SINGLE, REG_ORIGIN_X, 0, '{S_MIN, S_MIN, S_MAX, S_MAX},
                           '{0, 0, 0, 0, 1, 1, 1}});
    plan.push_back(step_t'{STEP_DROP, REG_ORIGIN_X, 0, '{3, 0, 3, 5}, NO_WORD});
    plan.push_back(step_t'{STEP_DROP, REG_ORIGIN_X, 0, '{0, 4, 2, 4}, NO_WORD});
    plan.push_back(step_t'{STEP_DROP, REG_ORIGIN_X, 0, '{S_MAX, S_MIN, S_MIN, S_MAX}, NO_WORD});
    plan.push_back(step_t'{STEP_DROP, REG_ORIGIN_X, 0, '{1, 0, 5, 1}, NO_WORD});
    plan.push_back(step_t'{STEP_DROP, REG_ORIGIN_X, 0, '{S_MIN, 0, 0, 1}, NO_WORD});
    plan.push_back(step_t'{STEP_DROP, REG_ORIGIN_X, 0, '{0, 1, 1, 5}, NO_WORD});
    // full 8x8 grid with a horizontal bloat
    plan.push_back(step_t'{STEP_CFG, REG_ORIGIN_X, -100, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_ORIGIN_Y, 50, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_COLUMNS, 8, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_ROWS, 8, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_BIN_WIDTH, 10, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_BIN_HEIGHT, 20, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_MARGIN_X, 3, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_MARGIN_Y, 0, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{S_MIN, S_MIN, S_MAX, S_MAX}, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{-95, 55, -94, 56}, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{-93, 50, -92, 51}, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{-30, 100, S_MAX, 110}, NO_WORD});
    // zero columns, oversized rows, zero pitch
    plan.push_back(step_t'{STEP_CFG, REG_COLUMNS, 0, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_ROWS, 32'hffff_ffff, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_BIN_WIDTH, 32'hc000_0000, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{S_MIN, S_MIN, S_MAX, S_MAX}, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{-100, 50, -99, S_MAX}, NO_WORD});
    // extreme origins, pitches and margins
    plan.push_back(step_t'{STEP_CFG, REG_ORIGIN_X, S_MAX, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_ORIGIN_Y, S_MIN, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_COLUMNS, 8, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_BIN_WIDTH, 32'h3fff_ffff, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_BIN_HEIGHT, 32'h3fff_ffff, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_MARGIN_X, 32'h3fff_ffff, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_MARGIN_Y, 32'h3fff_ffff, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{S_MIN, S_MIN, S_MAX, S_MAX}, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{S_MAX - 1, S_MIN, S_MAX, S_MIN + 1},
                           NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_ORIGIN_X, S_MIN, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_CFG, REG_ORIGIN_Y, S_MAX, NO_RECT, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{S_MIN, S_MIN, S_MAX, S_MAX}, NO_WORD});
    plan.push_back(step_t'{STEP_PREDICT, REG_ORIGIN_X, 0, '{S_MIN, S_MAX - 1, S_MIN + 5, S_MAX},
                           NO_WORD});

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    grid_count = 1;

    foreach (plan[n]) begin
      s = plan[n];
      case (s.kind)
        STEP_CFG: program_reg(s.idx, s.val);
        STEP_SINGLE: begin
          send_rect(s.rect);
          expected_bins.push_back(s.want);
        end
        STEP_DROP: send_rect(s.rect);
        default: begin
          send_rect(s.rect);
          predict_bins(s.rect);
        end
      endcase
    end

    for (int p = 0; p < 8; p++) begin
      random_grid();
      idle_mode = idle_e'(p % 4);
      if (p == 0) pressure_go = 1'b1;
      repeat (25) begin
        r = random_rect();
        send_rect(r);
        predict_bins(r);
      end
    end

    settle_stream();
    $display("covered %0d rectangles over %0d grid settings, %0d bin pieces scored",
             rect_count, grid_count, piece_count);
    $display("with free-running, sender-gapped, receiver-stalled and mixed traffic");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
